[design/assert_macros.svh]
// Assertion macros used by the checker file.
// Each macro expects i_clk, and all but CLX_ASSERT_NEXT_ALWAYS also i_rst_n, to exist in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked only while out of reset.
`define CLX_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked only while out of reset.
`define CLX_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication, checked during reset as well.
`define CLX_ASSERT_NEXT_ALWAYS(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/clx_pkg.sv]
package clx_pkg;

    localparam int MAX_TOKEN_LEN_DEF = 255;
    localparam int POS_WIDTH_DEF     = 32;

    // Keyword spellings packed as they enter the prefix register.
    localparam logic [47:0] KW_INT        = 48'h00_00_00_69_6E_74;
    localparam logic [47:0] KW_RETURN     = 48'h72_65_74_75_72_6E;
    localparam int          KW_INT_LEN    = 3;
    localparam int          KW_RETURN_LEN = 6;
    localparam int          PREFIX_BYTES  = 6;

    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_SEMI   = 8'h3B;

    localparam logic [7:0] OUT_LEN_MAX = 8'hFF;

    // Token queue: deep enough to take two tokens while two more wait.
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [0:0] {
        OP_CHAR  = 1'b0,
        OP_FLUSH = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        MODE_IDLE   = 2'd0,
        MODE_IDENT  = 2'd1,
        MODE_NUMBER = 2'd2
    } t_mode;

    typedef enum logic [3:0] {
        TT_INT_KW    = 4'd0,
        TT_RETURN_KW = 4'd1,
        TT_IDENT     = 4'd2,
        TT_LPAREN    = 4'd3,
        TT_RPAREN    = 4'd4,
        TT_LBRACE    = 4'd5,
        TT_RBRACE    = 4'd6,
        TT_INT_LIT   = 4'd7,
        TT_SEMI      = 4'd8,
        TT_UNKNOWN   = 4'd9
    } t_tok_type;

    typedef struct packed {
        t_op        op;
        logic [7:0] char_byte;
    } t_item;

    typedef struct packed {
        t_tok_type   token_type;
        logic [31:0] start_pos;
        logic [7:0]  token_len;
        logic        too_long;
        logic        last;
    } t_token;

    // Tokens produced by one item: count is 0, 1 or 2, tok0 goes out first.
    typedef struct packed {
        logic [1:0] count;
        t_token     tok0;
        t_token     tok1;
    } t_scan_out;

    function automatic logic is_letter(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function automatic t_tok_type single_type(input logic [7:0] c);
        t_tok_type t;
        unique case (c)
            CH_LPAREN: t = TT_LPAREN;
            CH_RPAREN: t = TT_RPAREN;
            CH_LBRACE: t = TT_LBRACE;
            CH_RBRACE: t = TT_RBRACE;
            CH_SEMI:   t = TT_SEMI;
            default:   t = TT_UNKNOWN;
        endcase
        return t;
    endfunction

endpackage

[design/clx_if.sv]
interface clx_in_if;
    logic       valid;
    logic       ready;
    logic       op;
    logic [7:0] char_byte;

    modport source (output valid, output op, output char_byte, input ready);
    modport sink   (input valid, input op, input char_byte, output ready);
endinterface

interface clx_tok_if;
    logic        valid;
    logic        ready;
    logic [3:0]  token_type;
    logic [31:0] start_pos;
    logic [7:0]  token_len;
    logic        too_long;
    logic        last;

    modport source (output valid, output token_type, output start_pos, output token_len,
                    output too_long, output last, input ready);
    modport sink   (input valid, input token_type, input start_pos, input token_len,
                    input too_long, input last, output ready);
endinterface

[design/clx_scan.sv]
module clx_scan import clx_pkg::*; #(
    parameter int MAX_TOKEN_LEN = MAX_TOKEN_LEN_DEF,
    parameter int POS_WIDTH     = POS_WIDTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_fire,
    input  t_item     i_item,
    output t_scan_out o_res
);

    localparam int             LW      = $clog2(MAX_TOKEN_LEN + 1);
    localparam logic [LW-1:0]  LEN_MAX = LW'(MAX_TOKEN_LEN);

    t_mode                r_mode,   n_mode;
    logic [POS_WIDTH-1:0] r_pos,    n_pos;
    logic [POS_WIDTH-1:0] r_start,  n_start;
    logic [LW-1:0]        r_len,    n_len;
    logic [47:0]          r_prefix, n_prefix;
    logic                 r_ovf,    n_ovf;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_IDLE;
            r_pos    <= '0;
            r_start  <= '0;
            r_len    <= '0;
            r_prefix <= '0;
            r_ovf    <= 1'b0;
        end else begin
            r_mode   <= n_mode;
            r_pos    <= n_pos;
            r_start  <= n_start;
            r_len    <= n_len;
            r_prefix <= n_prefix;
            r_ovf    <= n_ovf;
        end
    end

    always_comb begin
        logic       c_let, c_dig, c_sp, c_char, c_grow, c_flush, c_single;
        logic [7:0]  c;
        logic [63:0] start_ext, pos_ext;
        logic [15:0] len_ext;
        t_token      pend, sing;

        c        = i_item.char_byte;
        c_char   = (i_item.op == OP_CHAR);
        c_let    = is_letter(c);
        c_dig    = is_digit(c);
        c_sp     = is_space(c);
        c_grow   = c_char && ((r_mode == MODE_IDENT && (c_let || c_dig)) ||
                              (r_mode == MODE_NUMBER && c_dig));
        c_flush  = !c_grow && (r_mode != MODE_IDLE);
        c_single = c_char && !c_grow && !c_sp && !c_let && !c_dig;

        start_ext = 64'(r_start);
        pos_ext   = 64'(r_pos);
        len_ext   = 16'(r_len);

        // Pending identifier or number, as it stands before this item.
        if (r_mode == MODE_NUMBER) begin
            pend.token_type = TT_INT_LIT;
        end else if (r_len == LW'(KW_INT_LEN) && !r_ovf && r_prefix == KW_INT) begin
            pend.token_type = TT_INT_KW;
        end else if (r_len == LW'(KW_RETURN_LEN) && !r_ovf && r_prefix == KW_RETURN) begin
            pend.token_type = TT_RETURN_KW;
        end else begin
            pend.token_type = TT_IDENT;
        end
        pend.start_pos = start_ext[31:0];
        pend.token_len = (len_ext > 16'(OUT_LEN_MAX)) ? OUT_LEN_MAX : len_ext[7:0];
        pend.too_long  = r_ovf;
        pend.last      = !c_single;

        sing.token_type = single_type(c);
        sing.start_pos  = pos_ext[31:0];
        sing.token_len  = 8'd1;
        sing.too_long   = 1'b0;
        sing.last       = 1'b1;

        o_res.count = {1'b0, c_flush} + {1'b0, c_single};
        o_res.tok0  = c_flush ? pend : sing;
        o_res.tok1  = sing;

        n_mode   = r_mode;
        n_pos    = r_pos;
        n_start  = r_start;
        n_len    = r_len;
        n_prefix = r_prefix;
        n_ovf    = r_ovf;

        if (i_fire) begin
            if (!c_char) begin
                n_mode   = MODE_IDLE;
                n_pos    = '0;
                n_start  = '0;
                n_len    = '0;
                n_prefix = '0;
                n_ovf    = 1'b0;
            end else begin
                if (c_grow) begin
                    if (r_len < LW'(PREFIX_BYTES)) begin
                        n_prefix = {r_prefix[39:0], c};
                    end
                    if (r_len == LEN_MAX) begin
                        n_ovf = 1'b1;
                    end else begin
                        n_len = r_len + LW'(1);
                    end
                end else begin
                    if (c_flush) begin
                        n_mode   = MODE_IDLE;
                        n_len    = '0;
                        n_prefix = '0;
                        n_ovf    = 1'b0;
                    end
                    if (c_let || c_dig) begin
                        n_mode   = c_let ? MODE_IDENT : MODE_NUMBER;
                        n_start  = r_pos;
                        n_len    = LW'(1);
                        n_prefix = 48'(c);
                        n_ovf    = 1'b0;
                    end
                end
                n_pos = r_pos + POS_WIDTH'(1);
            end
        end
    end

endmodule

[design/clx_outq.sv]
module clx_outq import clx_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [1:0]       i_wr_cnt,
    input  t_token           i_tok0,
    input  t_token           i_tok1,
    output logic             o_room,
    clx_tok_if.source        o_tok
);

    t_token               r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]  r_wp, n_wp;
    logic [QUEUE_AW-1:0]  r_rp, n_rp;
    logic [QUEUE_CW-1:0]  r_cnt, n_cnt;
    logic                 rd;
    logic [QUEUE_AW-1:0]  wp1;
    t_token               head;

    assign wp1    = r_wp + QUEUE_AW'(1);
    assign o_room = r_cnt <= QUEUE_CW'(QUEUE_DEPTH - 2);
    assign rd     = o_tok.valid && o_tok.ready;

    assign head             = r_mem[r_rp];
    assign o_tok.valid      = r_cnt != '0;
    assign o_tok.token_type = head.token_type;
    assign o_tok.start_pos  = head.start_pos;
    assign o_tok.token_len  = head.token_len;
    assign o_tok.too_long   = head.too_long;
    assign o_tok.last       = head.last;

    always_comb begin
        n_wp  = r_wp + QUEUE_AW'(i_wr_cnt);
        n_rp  = rd ? r_rp + QUEUE_AW'(1) : r_rp;
        n_cnt = r_cnt + QUEUE_CW'(i_wr_cnt) - QUEUE_CW'(rd);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_cnt != 2'd0) begin
            r_mem[r_wp] <= i_tok0;
        end
        if (i_wr_cnt == 2'd2) begin
            r_mem[wp1] <= i_tok1;
        end
    end

endmodule

[design/c_subset_token_lexer_core.sv]
// Channel   Dir  Payload                                            Handshake
// i_src     in   op, char_byte                                      valid/ready
// o_tok     out  token_type, start_pos, token_len, too_long, last   valid/ready
//
// One source byte per cycle is accepted while the input is not stalled; a byte
// passes through the input register into the token queue, whose head drives o_tok.
// A byte may produce up to two tokens, so a held byte waits in the input register
// until the four-entry token queue has two free slots, and the input stalls while
// a byte waits there; output drain of one token per cycle sets the sustained rate
// for bytes that produce two tokens.
// i_rst_n is synchronous and active low; it clears the scanner state and the queue.
module c_subset_token_lexer_core import clx_pkg::*; #(
    parameter int MAX_TOKEN_LEN = MAX_TOKEN_LEN_DEF,
    parameter int POS_WIDTH     = POS_WIDTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    clx_in_if.sink     i_src,
    clx_tok_if.source  o_tok
);

    // Input register: holds one accepted transaction until the queue has room
    // for every token that byte can produce.
    logic      r_vld;
    t_item     r_item;
    logic      room;
    logic      adv;
    t_scan_out scan_res;

    // The scanner consumes the held byte when the queue can take two tokens.
    assign adv         = r_vld && room;
    // A new byte enters whenever the register is empty or is being drained now,
    // so back-to-back bytes flow without a bubble.
    assign i_src.ready = !r_vld || adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_src.ready) begin
            r_vld <= i_src.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_src.valid && i_src.ready) begin
            r_item.op        <= t_op'(i_src.op);
            r_item.char_byte <= i_src.char_byte;
        end
    end

    // Classification, token assembly and the lexer state registers.
    clx_scan #(
        .MAX_TOKEN_LEN (MAX_TOKEN_LEN),
        .POS_WIDTH     (POS_WIDTH)
    ) u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (adv),
        .i_item  (r_item),
        .o_res   (scan_res)
    );

    // Result registers: a small queue that takes up to two tokens per cycle
    // and hands them out one per transaction.
    clx_outq u_outq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr_cnt (adv ? scan_res.count : 2'd0),
        .i_tok0   (scan_res.tok0),
        .i_tok1   (scan_res.tok1),
        .o_room   (room),
        .o_tok    (o_tok)
    );

endmodule

[design/clx_checker.sv]
`include "assert_macros.svh"

module clx_checker import clx_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [3:0]  i_token_type,
    input logic [31:0] i_start_pos,
    input logic [7:0]  i_token_len,
    input logic        i_too_long,
    input logic        i_last
);

    logic single_char;
    logic keyword;

    assign single_char = i_token_type == TT_LPAREN || i_token_type == TT_RPAREN ||
                         i_token_type == TT_LBRACE || i_token_type == TT_RBRACE ||
                         i_token_type == TT_SEMI   || i_token_type == TT_UNKNOWN;
    assign keyword     = i_token_type == TT_INT_KW || i_token_type == TT_RETURN_KW;

    // A stalled token keeps its contents.
    `CLX_ASSERT_NEXT(a_hold, i_out_valid && !i_out_ready, i_out_valid && $stable(i_token_type) && $stable(i_start_pos) && $stable(i_token_len) && $stable(i_last), "token changed while stalled")

    // Reset empties the token queue.
    `CLX_ASSERT_NEXT_ALWAYS(a_rst_empty, !i_rst_n, !i_out_valid, "token valid after reset")

    // Punctuation and unknown bytes are one character long and never overlong;
    // a pending token flushed ahead of one of them is never marked last.
    `CLX_ASSERT_NOW(a_single, i_out_valid && single_char, i_token_len == 8'd1 && !i_too_long && i_last, "bad single-character token")

    // Keywords have exactly their spelled length and are never overlong.
    `CLX_ASSERT_NOW(a_keyword, i_out_valid && keyword, !i_too_long && ((i_token_type == TT_INT_KW && i_token_len == 8'd3) || (i_token_type == TT_RETURN_KW && i_token_len == 8'd6)), "bad keyword length")

endmodule

bind c_subset_token_lexer_core clx_checker u_clx_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_out_valid  (o_tok.valid),
    .i_out_ready  (o_tok.ready),
    .i_token_type (o_tok.token_type),
    .i_start_pos  (o_tok.start_pos),
    .i_token_len  (o_tok.token_len),
    .i_too_long   (o_tok.too_long),
    .i_last       (o_tok.last)
);
